// ----- hw/rtl/mbc_pkg.sv -----
// Shared constants, types and helper functions of the metronome click generator.
`default_nettype none

package mbc_pkg;

  localparam int FPB_W        = 24;
  localparam int METER_W      = 4;
  localparam int MASK_W       = 12;
  localparam int CLEN_W       = 12;
  localparam int OFS_W        = 17;
  localparam int POS_W        = 4;
  localparam int SAMPLE_W     = 16;
  localparam int TADDR_W      = 11;
  localparam int VC_W         = 25;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int MAX_BEATS    = 12;
  localparam int CLICK_DEPTH_DEF = 2048;
  localparam int S_TDATA_W    = 32;
  localparam int S_TUSER_W    = 2;
  localparam int M_TDATA_W    = 32;

  localparam logic OP_FRAME       = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;
  localparam logic TABLE_NORMAL   = 1'b0;
  localparam logic TABLE_ACCENT   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_PER_BEAT = 3'd0,
    REG_METER_BEATS     = 3'd1,
    REG_ACCENT_MASK     = 3'd2,
    REG_CLICK_LENGTH    = 3'd3,
    REG_VOICE_OFFSET    = 3'd4,
    REG_FIRST_BEAT_ONLY = 3'd5,
    REG_VOICE_ENABLE    = 3'd6
  } cfg_reg_t;

  // Per-frame results of the scheduler, before the click sample arrives.
  typedef struct packed {
    logic             play;
    logic             play_accent;
    logic             beat_start;
    logic [POS_W-1:0] beat_index;
    logic             beat_accent;
    logic             voice_start;
    logic [POS_W-1:0] voice_beat;
  } mbc_frame_t;

  // Effective meter: zero reads as one, large values saturate.
  function automatic logic [POS_W-1:0] meter_clamp(input logic [METER_W-1:0] v);
    logic [POS_W-1:0] m;
    m = POS_W'(v);
    if (v == '0) m = POS_W'(1);
    else if (32'(v) > MAX_BEATS) m = POS_W'(MAX_BEATS);
    return m;
  endfunction

  // Narrow remainder by conditional subtraction of shifted divisors.
  function automatic logic [POS_W-1:0] mod_small(input logic [POS_W-1:0] x,
                                                 input logic [POS_W-1:0] m);
    logic [2*POS_W-1:0] r;
    logic [2*POS_W-1:0] md;
    r  = (2*POS_W)'(x);
    md = (2*POS_W)'(m);
    for (int k = POS_W - 1; k >= 0; k--) begin
      if (r >= (md << k)) r = r - (md << k);
    end
    return r[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/metronome_beat_click_generator_unit.sv -----
// Top level of the metronome beat and click generator: stream ports, pipeline and output register.
`default_nettype none

// Each input transaction is either one audio frame or one click table word, and
// each produces exactly one output transaction. The block takes one transaction
// per clock cycle while nothing stalls it; the scheduler and table read fill
// stage 1, sample select writes the output register in stage 2, and a held
// output stalls the input only once both stages are full. Click tables are
// synchronous memories with one write port and one registered read port; a word
// written by one transaction is visible to any later frame. A changed
// frames_per_beat or any voice_offset_frames write that places the next voice
// cue behind the current frame starts a realignment (17 divider steps and one
// finishing step) during which neither the configuration port nor the input
// accepts. Table entries never written read back undefined; there is no
// clearing pass after reset.
module metronome_beat_click_generator_unit
  import mbc_pkg::*;
#(
  parameter int CLICK_DEPTH = CLICK_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [10:0] table_address, [26:11] table_value, [31:27] zero
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation, [1] table_select
  input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [15:0] click_sample, [16] beat_start, [20:17] beat_index, [21] beat_accent,
  // [22] voice_start, [26:23] voice_beat, [31:27] zero
  output logic      [M_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(CLICK_DEPTH);

  logic                 in_acc;
  logic                 op;
  logic                 tsel;
  logic [TADDR_W-1:0]   taddr;
  logic [SAMPLE_W-1:0]  tvalue;
  logic [31:0]          taddr_ext;
  logic                 frame_step;
  logic                 wr_en;
  logic                 rd_en;
  logic                 idle;
  logic [AW-1:0]        click_addr;
  mbc_frame_t           frame;
  logic [SAMPLE_W-1:0]  rd_normal;
  logic [SAMPLE_W-1:0]  rd_accent;

  logic                 s1_valid;
  mbc_frame_t           s1_frame;
  logic                 s1_adv;
  logic [SAMPLE_W-1:0]  sample;
  logic                 s2_valid;
  logic [M_TDATA_W-1:0] s2_data;

  // Unpack the input transaction.
  assign op        = s_axis_tuser[0];
  assign tsel      = s_axis_tuser[1];
  assign taddr     = s_axis_tdata[TADDR_W-1:0];
  assign tvalue    = s_axis_tdata[TADDR_W +: SAMPLE_W];
  assign taddr_ext = 32'(taddr);

  // Stage 1 frees when its result moves to the output register.
  assign s1_adv        = s1_valid && (!s2_valid || m_axis_tready);
  // Configuration has priority over a frame presented in the same cycle.
  assign s_axis_tready = idle && !cfg_valid && (!s1_valid || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign frame_step    = in_acc && (op == OP_FRAME);
  // Drop writes beyond the table depth.
  assign wr_en         = in_acc && (op == OP_TABLE_WRITE) && (taddr_ext < CLICK_DEPTH);
  assign rd_en         = frame_step && frame.play;

  mbc_beat_sched #(
    .CLICK_DEPTH(CLICK_DEPTH)
  ) u_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .frame_step (frame_step),
    .idle       (idle),
    .click_addr (click_addr),
    .frame      (frame)
  );

  mbc_click_mem #(
    .CLICK_DEPTH(CLICK_DEPTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_sel    (tsel),
    .wr_addr   (taddr_ext[AW-1:0]),
    .wr_data   (tvalue),
    .rd_en     (rd_en),
    .rd_addr   (click_addr),
    .rd_normal (rd_normal),
    .rd_accent (rd_accent)
  );

  // Stage 1: hold the frame flags while the table read completes. Read data
  // only changes on a new read, so it stays put while this stage is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_frame <= frame;
  end

  // Silent frames and table writes carry a zero sample.
  always_comb begin
    sample = '0;
    if (s1_frame.play) sample = s1_frame.play_accent ? rd_accent : rd_normal;
  end

  // Stage 2: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (m_axis_tready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_data <= M_TDATA_W'({s1_frame.voice_beat, s1_frame.voice_start,
                             s1_frame.beat_accent, s1_frame.beat_index,
                             s1_frame.beat_start, sample});
    end
  end

  assign m_axis_tvalid = s2_valid;
  assign m_axis_tdata  = s2_data;

endmodule

`default_nettype wire

// ----- hw/rtl/mbc_click_mem.sv -----
// Normal and accent click sample tables, one write port and one registered read port.
`default_nettype none

module mbc_click_mem
  import mbc_pkg::*;
#(
  parameter int CLICK_DEPTH = CLICK_DEPTH_DEF,
  localparam int AW = $clog2(CLICK_DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic                wr_sel,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [SAMPLE_W-1:0] wr_data,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output logic      [SAMPLE_W-1:0] rd_normal,
  output logic      [SAMPLE_W-1:0] rd_accent
);

  logic [SAMPLE_W-1:0] normal_mem [CLICK_DEPTH];
  logic [SAMPLE_W-1:0] accent_mem [CLICK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en && wr_sel == TABLE_NORMAL) normal_mem[wr_addr] <= wr_data;
    if (rd_en) rd_normal <= normal_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_sel == TABLE_ACCENT) accent_mem[wr_addr] <= wr_data;
    if (rd_en) rd_accent <= accent_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mbc_beat_sched.sv -----
// Configuration registers, beat, click and voice counters, and the voice realignment divider.
`default_nettype none

module mbc_beat_sched
  import mbc_pkg::*;
#(
  parameter int CLICK_DEPTH = CLICK_DEPTH_DEF,
  localparam int AW = $clog2(CLICK_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       cfg_ready,
  input  wire logic                  frame_step,
  output logic                       idle,
  output logic [AW-1:0]              click_addr,
  output mbc_frame_t                 frame
);

  localparam int LEN_W     = $clog2(CLICK_DEPTH + 1);
  localparam int DIV_STEPS = OFS_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int T_W       = VC_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } div_state_t;

  div_state_t        state, state_next;
  logic [FPB_W-1:0]  fpb, fpb_next;
  logic [METER_W-1:0] meter_r, meter_next;
  logic [MASK_W-1:0] mask, mask_next;
  logic [CLEN_W-1:0] clen, clen_next;
  logic [OFS_W-1:0]  ofs, ofs_next;
  logic              fbo, fbo_next;
  logic              ven, ven_next;
  logic [FPB_W-1:0]  ftb, ftb_next;
  logic [POS_W-1:0]  bpos, bpos_next;
  logic              cactive, cactive_next;
  logic              caccent, caccent_next;
  logic [AW-1:0]     cpos, cpos_next;
  logic [VC_W-1:0]   vc, vc_next;
  logic [POS_W-1:0]  vpos, vpos_next;
  logic [FPB_W-1:0]  div_rem, div_rem_next;
  logic [OFS_W-1:0]  div_n, div_n_next;
  logic [POS_W-1:0]  div_qm, div_qm_next;
  logic [CNT_W-1:0]  div_cnt, div_cnt_next;

  logic [POS_W-1:0]  m_eff;
  logic [POS_W-1:0]  m_new;
  logic [FPB_W-1:0]  per;
  logic [LEN_W-1:0]  len_eff;
  logic              realign;
  logic [T_W-1:0]    t_sum;
  logic [FPB_W:0]    r2;
  logic              ge;
  logic [POS_W:0]    qm2;
  logic [POS_W:0]    jm;
  logic [POS_W:0]    psum;
  logic              beat;
  logic [POS_W-1:0]  pos_inc;
  logic [AW-1:0]     play_pos;
  logic [POS_W-1:0]  vpos_inc;

  always_comb begin
    m_eff = meter_clamp(meter_r);
    per   = (fpb == '0) ? FPB_W'(1) : fpb;
    if (clen == '0) len_eff = LEN_W'(1);
    else if (32'(clen) > CLICK_DEPTH) len_eff = LEN_W'(CLICK_DEPTH);
    else len_eff = LEN_W'(clen);
  end

  assign cfg_ready = (state == S_IDLE);
  assign idle      = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    fpb_next     = fpb;
    meter_next   = meter_r;
    mask_next    = mask;
    clen_next    = clen;
    ofs_next     = ofs;
    fbo_next     = fbo;
    ven_next     = ven;
    ftb_next     = ftb;
    bpos_next    = bpos;
    cactive_next = cactive;
    caccent_next = caccent;
    cpos_next    = cpos;
    vc_next      = vc;
    vpos_next    = vpos;
    div_rem_next = div_rem;
    div_n_next   = div_n;
    div_qm_next  = div_qm;
    div_cnt_next = div_cnt;
    frame        = '0;
    click_addr   = '0;
    realign      = 1'b0;
    m_new        = meter_clamp(cfg_data[METER_W-1:0]);
    t_sum        = '0;
    r2           = '0;
    ge           = 1'b0;
    qm2          = '0;
    jm           = '0;
    psum         = '0;
    beat         = 1'b0;
    pos_inc      = '0;
    play_pos     = '0;
    vpos_inc     = '0;

    unique case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          unique case (cfg_index)
            REG_FRAMES_PER_BEAT: begin
              // Rewriting the same tempo leaves the schedule alone.
              if (cfg_data[FPB_W-1:0] != fpb) begin
                fpb_next = cfg_data[FPB_W-1:0];
                ftb_next = (cfg_data[FPB_W-1:0] == '0) ? FPB_W'(1) : cfg_data[FPB_W-1:0];
                realign  = 1'b1;
              end
            end
            REG_METER_BEATS: begin
              meter_next = cfg_data[METER_W-1:0];
              bpos_next  = mod_small(bpos, m_new);
              vpos_next  = mod_small(vpos, m_new);
            end
            REG_ACCENT_MASK:     mask_next = cfg_data[MASK_W-1:0];
            REG_CLICK_LENGTH:    clen_next = cfg_data[CLEN_W-1:0];
            REG_VOICE_OFFSET: begin
              ofs_next = cfg_data[OFS_W-1:0];
              realign  = 1'b1;
            end
            REG_FIRST_BEAT_ONLY: fbo_next = cfg_data[0];
            REG_VOICE_ENABLE:    ven_next = cfg_data[0];
            default: ;
          endcase

          if (realign) begin
            t_sum = T_W'(ftb_next) + {{(T_W-OFS_W){ofs_next[OFS_W-1]}}, ofs_next};
            if (!t_sum[T_W-1]) begin
              vc_next   = t_sum[VC_W-1:0];
              vpos_next = bpos;
            end else begin
              // Cue falls before now: push it forward by whole periods.
              div_n_next   = OFS_W'(-t_sum);
              div_rem_next = '0;
              div_qm_next  = '0;
              div_cnt_next = '0;
              state_next   = S_DIV;
            end
          end
        end else if (frame_step) begin
          beat = (ftb == '0);
          if (beat) begin
            pos_inc = (bpos + POS_W'(1) == m_eff) ? '0 : bpos + POS_W'(1);
            frame.beat_start  = 1'b1;
            frame.beat_index  = bpos;
            frame.beat_accent = (32'(bpos) < MASK_W) ? mask[bpos] : 1'b0;
            bpos_next = pos_inc;
            ftb_next  = per - FPB_W'(1);
          end else begin
            ftb_next = ftb - FPB_W'(1);
          end

          // Click playback: a beat restarts the chosen table from sample zero.
          play_pos          = beat ? '0 : cpos;
          frame.play        = beat | cactive;
          frame.play_accent = beat ? frame.beat_accent : caccent;
          click_addr        = play_pos;
          if (beat) caccent_next = frame.beat_accent;
          if (frame.play) begin
            if (LEN_W'(play_pos) + LEN_W'(1) >= len_eff) begin
              cactive_next = 1'b0;
              cpos_next    = '0;
            end else begin
              cactive_next = 1'b1;
              cpos_next    = play_pos + AW'(1);
            end
          end

          // Voice schedule: countdown never goes below zero.
          if (vc == '0) begin
            vpos_inc = (vpos + POS_W'(1) == m_eff) ? '0 : vpos + POS_W'(1);
            if (ven && (!fbo || vpos == '0)) begin
              frame.voice_start = 1'b1;
              frame.voice_beat  = vpos + POS_W'(1);
            end
            vpos_next = vpos_inc;
            vc_next   = VC_W'(per) - VC_W'(1);
          end else begin
            vc_next = vc - VC_W'(1);
          end
        end
      end

      S_DIV: begin
        // One quotient bit per cycle; keep the quotient modulo the meter.
        r2 = {div_rem, div_n[OFS_W-1]};
        ge = (r2 >= {1'b0, per});
        div_rem_next = ge ? FPB_W'(r2 - {1'b0, per}) : r2[FPB_W-1:0];
        qm2 = {div_qm, 1'b0} + (POS_W+1)'(ge);
        if (qm2 >= {1'b0, m_eff}) qm2 = qm2 - {1'b0, m_eff};
        div_qm_next  = qm2[POS_W-1:0];
        div_n_next   = {div_n[OFS_W-2:0], 1'b0};
        div_cnt_next = div_cnt + CNT_W'(1);
        if (div_cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_DONE;
      end

      S_DONE: begin
        // Round the quotient up and land the cue on the next period boundary.
        jm = {1'b0, div_qm} + (POS_W+1)'(div_rem != '0);
        if (jm >= {1'b0, m_eff}) jm = jm - {1'b0, m_eff};
        psum = {1'b0, bpos} + jm;
        if (psum >= {1'b0, m_eff}) psum = psum - {1'b0, m_eff};
        vpos_next  = psum[POS_W-1:0];
        vc_next    = (div_rem == '0) ? '0 : VC_W'(per - div_rem);
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fpb     <= FPB_W'(24000);
      meter_r <= METER_W'(4);
      mask    <= MASK_W'(1);
      clen    <= CLEN_W'(1440);
      ofs     <= '0;
      fbo     <= 1'b0;
      ven     <= 1'b0;
      ftb     <= '0;
      bpos    <= '0;
      cactive <= 1'b0;
      caccent <= 1'b0;
      cpos    <= '0;
      vc      <= '0;
      vpos    <= '0;
    end else begin
      state   <= state_next;
      fpb     <= fpb_next;
      meter_r <= meter_next;
      mask    <= mask_next;
      clen    <= clen_next;
      ofs     <= ofs_next;
      fbo     <= fbo_next;
      ven     <= ven_next;
      ftb     <= ftb_next;
      bpos    <= bpos_next;
      cactive <= cactive_next;
      caccent <= caccent_next;
      cpos    <= cpos_next;
      vc      <= vc_next;
      vpos    <= vpos_next;
    end
  end

  always_ff @(posedge clk) begin
    div_rem <= div_rem_next;
    div_n   <= div_n_next;
    div_qm  <= div_qm_next;
    div_cnt <= div_cnt_next;
  end

  a_bpos_in_meter: assert property (@(posedge clk) disable iff (rst) bpos < m_eff)
    else $error("beat position outside meter");
  a_vpos_in_meter: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> vpos < m_eff)
    else $error("voice position outside meter");
  a_div_length: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_DIV) |-> ##(DIV_STEPS) state == S_DONE ##1 state == S_IDLE)
    else $error("realignment divider ran for the wrong number of cycles");
  a_no_frame_busy: assert property (@(posedge clk) disable iff (rst)
    frame_step |-> state == S_IDLE && !cfg_valid)
    else $error("frame stepped during realignment or configuration");

endmodule

`default_nettype wire
